[rtl/core/sds_pkg.sv]
// Package for the spring-damper scroll smoother: types, register codes, reset values, saturation helpers.
package sds_pkg;

	localparam logic [31:0] RST_STIFF = 32'd13107200;
	localparam logic [31:0] RST_DAMP  = 32'd1853662;
	localparam logic [30:0] RST_THR   = 31'd655;

	// register word indexes
	localparam logic [1:0] REG_STIFF = 2'd0;
	localparam logic [1:0] REG_DAMP  = 2'd1;
	localparam logic [1:0] REG_THR   = 2'd2;

	// input modes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_SET  = 2'd1;
	localparam logic [1:0] MODE_MOVE = 2'd2;
	localparam logic [1:0] MODE_SNAP = 2'd3;

	// serial squarer phases: threshold, distance x/y, speed x/y, finished
	localparam logic [2:0] SQ_THR  = 3'd0;
	localparam logic [2:0] SQ_DA   = 3'd1;
	localparam logic [2:0] SQ_DB   = 3'd2;
	localparam logic [2:0] SQ_VA   = 3'd3;
	localparam logic [2:0] SQ_VB   = 3'd4;
	localparam logic [2:0] SQ_DONE = 3'd5;

	// width of the serial multiplier operand counter
	localparam int MUL_BITS = 32;
	localparam int CNT_W    = $clog2(MUL_BITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GOAL,
		ST_DIFF,
		ST_MUL,
		ST_ACC,
		ST_VEL,
		ST_POS,
		ST_CHK,
		ST_OUT
	} state_t;

	// saturate a 34-bit signed value to 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -34'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// saturate a full 64-bit product after floor shift by 16
	function automatic logic signed [31:0] satq(input logic signed [63:0] p);
		logic signed [47:0] s;
		logic signed [31:0] r;
		s = p[63:16];
		if (s > 48'sh0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (s < -48'sh0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = s[31:0];
		return r;
	endfunction

endpackage

[rtl/core/spring_damper_scroll_smoother_core.sv]
// Top level of the two-axis spring-damper scroll smoother.
// One transaction on s_axis gives one result on m_axis. A snap, or a tick while idle, goes
// straight from the goal step to the output step; a set or move goal first runs the threshold
// check, and a tick while animating runs its products and then the check. Time is set by one
// shift-add multiplier that retires one multiplier bit per cycle and is shared by the eight
// products of a tick (stiffness times distance, damping times speed, accel times dt and speed
// times dt, for each axis in turn), and by a serial squarer that forms the squared threshold,
// the two squared distances and, after a tick, the two squared speeds. Mode codes ride in
// tuser. The result waits in an output register; the next transaction may be taken while it
// waits, and the core holds at its output step until the register is free.
module spring_damper_scroll_smoother_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // value_x[31:0], value_y[63:32], time_step[79:64]
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // pos_x[31:0], pos_y[63:32]
	output logic        m_axis_tuser   // moving
);
	import sds_pkg::*;

	logic [31:0] stiff_q, damp_q;
	logic [30:0] thr_q;
	logic signed [31:0] gx_q, gy_q, px_q, py_q, vx_q, vy_q;
	logic run_q;

	// captured item
	logic [1:0]  mode_q;
	logic signed [31:0] inx_q, iny_q;
	logic [15:0] dt_q;

	state_t st_q, st_d;
	logic ax_q; // axis under work: 0 x, 1 y
	logic [2:0] op_q; // product number within an axis: 0 k*d, 1 c*v, 2 a*dt, 3 v*dt

	// serial multiplier
	logic signed [63:0] acc_q, mcand_q;
	logic [31:0] mplier_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [31:0] prod_q, kd_q, dx_q, dy_q;
	logic near_d_q;

	// result register
	logic out_v_q, out_ld;
	logic signed [31:0] ox_q, oy_q;
	logic omov_q;

	logic cfg_wr, in_acc;
	logic [1:0] cfg_idx;
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite;

	// register read
	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_STIFF: prdata = stiff_q;
			REG_DAMP:  prdata = damp_q;
			REG_THR:   prdata = {1'b0, thr_q};
			default:   prdata = '0;
		endcase
	end

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= RST_STIFF;
			damp_q  <= RST_DAMP;
			thr_q   <= RST_THR;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_STIFF: stiff_q <= (pwdata == '0) ? RST_STIFF : pwdata;
				REG_DAMP:  damp_q  <= (pwdata == '0) ? RST_DAMP : pwdata;
				REG_THR:   thr_q   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_acc = s_axis_tvalid & s_axis_tready;
	assign out_ld = (st_q == ST_OUT) && (!out_v_q || m_axis_tready);

	// current axis operands
	logic signed [31:0] cur_v;
	assign cur_v = ax_q ? vy_q : vx_q;

	// squared-magnitude compare against thr^2 on a serial squarer
	logic [32:0] sq_a_q, sq_b_q, sq_opnd;
	logic [65:0] sqsum_q, sq_sum;
	logic [2:0]  sq_ph_q; // which square is running
	logic        sq_mode_q; // 0 check-after-goal, 1 check-after-tick
	logic [65:0] thr2_q;
	logic [63:0] sq_acc_q, sq_cand_q;
	logic [32:0] sq_mp_q;

	function automatic logic [32:0] mag33(input logic signed [33:0] v);
		logic [33:0] m;
		m = v[33] ? 34'(-v) : v;
		return (m > 34'h0_8000_0000) ? 33'h0_8000_0000 : m[32:0];
	endfunction

	// squarer operand of the current phase
	assign sq_opnd = (sq_ph_q == SQ_THR) ? {2'b00, thr_q} :
		((sq_ph_q == SQ_DA || sq_ph_q == SQ_VA) ? sq_a_q : sq_b_q);
	assign sq_sum = sqsum_q + 66'(sq_acc_q);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_acc) st_d = ST_GOAL;
			ST_GOAL: begin
				if (mode_q == MODE_SNAP) st_d = ST_OUT;
				else if (mode_q == MODE_TICK) st_d = run_q ? ST_DIFF : ST_OUT;
				else st_d = ST_CHK;
			end
			ST_DIFF: st_d = ST_MUL;
			ST_MUL:  if (cnt_q == CNT_W'(MUL_BITS)) st_d = ST_ACC;
			ST_ACC: begin
				if (op_q == 3'd0) st_d = ST_MUL;
				else if (op_q == 3'd1) st_d = ST_MUL;
				else if (op_q == 3'd2) st_d = ST_VEL;
				else st_d = ST_POS;
			end
			ST_VEL:  st_d = ST_MUL;
			ST_POS:  st_d = ax_q ? ST_CHK : ST_MUL;
			ST_CHK:  if (sq_ph_q == SQ_DONE) st_d = ST_OUT;
			ST_OUT:  if (out_ld) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// serial square unit control: one multiplier bit a cycle
	logic sq_busy_q;
	logic [5:0] sq_cnt_q;

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q <= '0; gy_q <= '0; px_q <= '0; py_q <= '0;
			vx_q <= '0; vy_q <= '0; run_q <= 1'b0;
			ax_q <= 1'b0; op_q <= '0; cnt_q <= '0;
			sq_ph_q <= SQ_THR; sq_busy_q <= 1'b0; sq_cnt_q <= '0;
			mode_q <= MODE_TICK; inx_q <= '0; iny_q <= '0; dt_q <= '0;
			acc_q <= '0; mcand_q <= '0; mplier_q <= '0;
			prod_q <= '0; kd_q <= '0; dx_q <= '0; dy_q <= '0; near_d_q <= 1'b0;
			sq_a_q <= '0; sq_b_q <= '0; sqsum_q <= '0; sq_mode_q <= 1'b0; thr2_q <= '0;
			sq_acc_q <= '0; sq_cand_q <= '0; sq_mp_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (in_acc) begin
					mode_q <= s_axis_tuser;
					inx_q  <= s_axis_tdata[31:0];
					iny_q  <= s_axis_tdata[63:32];
					dt_q   <= s_axis_tdata[79:64];
					ax_q   <= 1'b0;
					op_q   <= '0;
				end
				ST_GOAL: begin
					sq_ph_q <= SQ_THR; sq_busy_q <= 1'b0;
					if (mode_q == MODE_SET) begin
						gx_q <= inx_q; gy_q <= iny_q;
						sq_a_q <= mag33(34'(inx_q) - 34'(px_q));
						sq_b_q <= mag33(34'(iny_q) - 34'(py_q));
						sq_mode_q <= 1'b0;
					end else if (mode_q == MODE_MOVE) begin
						gx_q <= sat34(34'(gx_q) + 34'(inx_q));
						gy_q <= sat34(34'(gy_q) + 34'(iny_q));
						sq_a_q <= mag33(34'(sat34(34'(gx_q) + 34'(inx_q))) - 34'(px_q));
						sq_b_q <= mag33(34'(sat34(34'(gy_q) + 34'(iny_q))) - 34'(py_q));
						sq_mode_q <= 1'b0;
					end else if (mode_q == MODE_SNAP) begin
						px_q <= gx_q; py_q <= gy_q; vx_q <= '0; vy_q <= '0;
						run_q <= 1'b0;
					end
				end
				ST_DIFF: begin
					dx_q <= sat34(34'(gx_q) - 34'(px_q));
					dy_q <= sat34(34'(gy_q) - 34'(py_q));
					sq_a_q <= mag33(34'(sat34(34'(gx_q) - 34'(px_q))));
					sq_b_q <= mag33(34'(sat34(34'(gy_q) - 34'(py_q))));
					cnt_q <= '0;
					acc_q <= '0;
					mcand_q <= {32'd0, stiff_q};
					mplier_q <= sat34(34'(gx_q) - 34'(px_q));
				end
				ST_MUL: begin
					// shift-add over the multiplier bits; top bit weighs negative
					if (cnt_q < CNT_W'(MUL_BITS)) begin
						if (mplier_q[0]) begin
							if (cnt_q == CNT_W'(MUL_BITS - 1))
								acc_q <= acc_q - mcand_q;
							else
								acc_q <= acc_q + mcand_q;
						end
						mplier_q <= mplier_q >> 1;
						mcand_q  <= mcand_q <<< 1;
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						prod_q <= satq(acc_q);
					end
				end
				ST_ACC: begin
					if (op_q == 3'd0) kd_q <= prod_q;
					op_q <= (op_q == 3'd3) ? 3'd0 : op_q + 3'd1;
					cnt_q <= '0; acc_q <= '0;
					case (op_q)
						3'd0: begin
							mcand_q <= {32'd0, damp_q}; mplier_q <= cur_v;
						end
						3'd1: begin
							mcand_q <= 64'(sat34(34'(kd_q) - 34'(prod_q)));
							mplier_q <= {16'd0, dt_q};
						end
						default: begin
							mcand_q <= '0; mplier_q <= '0;
						end
					endcase
				end
				ST_VEL: begin
					if (ax_q) vy_q <= sat34(34'(vy_q) + 34'(prod_q));
					else vx_q <= sat34(34'(vx_q) + 34'(prod_q));
					mcand_q <= 64'(sat34(34'(cur_v) + 34'(prod_q)));
					mplier_q <= {16'd0, dt_q};
					cnt_q <= '0; acc_q <= '0;
				end
				ST_POS: begin
					if (ax_q) py_q <= sat34(34'(py_q) + 34'(prod_q));
					else px_q <= sat34(34'(px_q) + 34'(prod_q));
					ax_q <= 1'b1;
					mcand_q <= {32'd0, stiff_q}; mplier_q <= dy_q;
					cnt_q <= '0; acc_q <= '0;
					if (ax_q) begin
						sq_mode_q <= 1'b1;
						sq_ph_q <= SQ_THR; sq_busy_q <= 1'b0;
					end
				end
				ST_CHK: begin
					// start a square, shift it, then use it by phase
					if (!sq_busy_q) begin
						if (sq_ph_q != SQ_DONE) begin
							sq_busy_q <= 1'b1; sq_cnt_q <= '0; sq_acc_q <= '0;
							sq_cand_q <= 64'(sq_opnd);
							sq_mp_q   <= sq_opnd;
						end
					end else if (sq_cnt_q < 6'd33) begin
						if (sq_mp_q[0]) sq_acc_q <= sq_acc_q + sq_cand_q;
						sq_mp_q <= sq_mp_q >> 1;
						sq_cand_q <= sq_cand_q << 1;
						sq_cnt_q <= sq_cnt_q + 6'd1;
					end else begin
						sq_busy_q <= 1'b0;
						case (sq_ph_q)
							SQ_THR: begin
								thr2_q <= 66'(sq_acc_q);
								sq_ph_q <= SQ_DA;
							end
							SQ_DA: begin
								sqsum_q <= 66'(sq_acc_q);
								sq_ph_q <= SQ_DB;
							end
							SQ_DB: begin
								if (!sq_mode_q) begin
									if (sq_sum > thr2_q) run_q <= 1'b1;
									sq_ph_q <= SQ_DONE;
								end else begin
									near_d_q <= sq_sum < thr2_q;
									sq_a_q <= mag33(34'(vx_q));
									sq_b_q <= mag33(34'(vy_q));
									sq_ph_q <= SQ_VA;
								end
							end
							SQ_VA: begin
								sqsum_q <= 66'(sq_acc_q);
								sq_ph_q <= SQ_VB;
							end
							default: begin
								// both distance and speed inside the threshold: stop
								if (near_d_q && (sq_sum < thr2_q)) begin
									px_q <= gx_q; py_q <= gy_q;
									vx_q <= '0; vy_q <= '0; run_q <= 1'b0;
								end
								sq_ph_q <= SQ_DONE;
							end
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			ox_q <= '0; oy_q <= '0; omov_q <= 1'b0;
		end else if (out_ld) begin
			out_v_q <= 1'b1;
			ox_q <= px_q; oy_q <= py_q; omov_q <= run_q;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {oy_q, ox_q};
	assign m_axis_tuser  = omov_q;

`ifndef SYNTH
	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_axis_tready) |=> (out_v_q && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser))) else $error("result changed while stalled");
	// a result is raised only from the output state
	a_out_from_st: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(st_q) == ST_OUT) else $error("stray result");
	// snap leaves the block idle with zero speed
	a_snap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_GOAL && mode_q == MODE_SNAP) |=> (!run_q && vx_q == '0 && vy_q == '0))
		else $error("snap failed");
`endif

endmodule
